FILE: src/spc_pkg.sv
// Shared types and constants of the skyline point counter.
// Used by spc_walk and skyline_point_counter; no dependencies.
package spc_pkg;

  localparam int COORD_W = 16;  // signed Q8.8 coordinate
  localparam int CFG_W   = 5;   // width of both configuration registers
  localparam int OUT_W   = 11;  // width of the count fields of a result

  // configuration register indexes
  localparam logic REG_STORED_DIMS = 1'b0;
  localparam logic REG_EVAL_DIMS   = 1'b1;

  // job handed from the load side to the comparison walk
  typedef struct packed {
    logic [CFG_W-1:0] sd;   // effective stored dims (row stride)
    logic [CFG_W-1:0] ed;   // effective compared dims
    logic             ovf;  // a coordinate of this set was dropped
  } spc_job_t;

  // result of one set
  typedef struct packed {
    logic             overflow;
    logic [OUT_W-1:0] point_count;
    logic [OUT_W-1:0] skyline_count;
  } spc_result_t;

endpackage

FILE: src/spc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/spc_walk.sv
// Sequencer for one point set: point count by repeated subtraction, then
// the nested dominance walk, both on one shared subtractor. Uses spc_pkg.
module spc_walk #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_DIMS   = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  spc_pkg::spc_job_t                         job,
  input  logic [$clog2(MAX_POINTS*MAX_DIMS+1)-1:0]  total,
  output logic [$clog2(MAX_POINTS*MAX_DIMS)-1:0]    rd_addr_a,
  output logic [$clog2(MAX_POINTS*MAX_DIMS)-1:0]    rd_addr_b,
  input  logic [spc_pkg::COORD_W-1:0]               rd_data_a,
  input  logic [spc_pkg::COORD_W-1:0]               rd_data_b,
  output logic                                      res_valid,
  input  logic                                      res_ready,
  output spc_pkg::spc_result_t                      result
);

  localparam int DEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PT_W   = $clog2(MAX_POINTS + 1);
  localparam int SUB_W  = ((CNT_W > spc_pkg::COORD_W) ? CNT_W : spc_pkg::COORD_W) + 1;
  localparam int CW     = spc_pkg::CFG_W;

  typedef enum logic [6:0] {
    W_IDLE  = 7'b0000001,
    W_DIV   = 7'b0000010,
    W_ROW_I = 7'b0000100,
    W_ROW_J = 7'b0001000,
    W_READ  = 7'b0010000,
    W_CMP   = 7'b0100000,
    W_DONE  = 7'b1000000
  } walk_state_t;

  walk_state_t      state;
  logic [CNT_W-1:0] rem;
  logic [PT_W-1:0]  n;
  logic [PT_W-1:0]  i;
  logic [PT_W-1:0]  j;
  logic [PT_W-1:0]  sky;
  logic [CNT_W-1:0] base_i;
  logic [CNT_W-1:0] base_j;
  logic [CW-1:0]    k;
  logic [CW-1:0]    sd_r;
  logic [CW-1:0]    ed_r;
  logic             ovf_r;

  logic [SUB_W-1:0] op_x;
  logic [SUB_W-1:0] op_y;
  logic [SUB_W-1:0] diff;
  logic             neg;
  logic [CNT_W-1:0] sum_a;
  logic [CNT_W-1:0] sum_b;
  logic [CNT_W-1:0] sd_ext;
  logic [PT_W+spc_pkg::OUT_W-1:0] sky_wide;
  logic [PT_W+spc_pkg::OUT_W-1:0] n_wide;

  // shared subtractor: remainder minus stride, or coordinate a minus b
  always_comb begin
    if (state == W_CMP) begin
      op_x = {{(SUB_W-spc_pkg::COORD_W){rd_data_a[spc_pkg::COORD_W-1]}}, rd_data_a};
      op_y = {{(SUB_W-spc_pkg::COORD_W){rd_data_b[spc_pkg::COORD_W-1]}}, rd_data_b};
    end else begin
      op_x = {{(SUB_W-CNT_W){1'b0}}, rem};
      op_y = {{(SUB_W-CW){1'b0}}, sd_r};
    end
  end
  assign diff = op_x - op_y;
  assign neg  = diff[SUB_W-1];

  // coordinate addresses of rows i and j
  assign sd_ext    = {{(CNT_W-CW){1'b0}}, sd_r};
  assign sum_a     = base_i + {{(CNT_W-CW){1'b0}}, k};
  assign sum_b     = base_j + {{(CNT_W-CW){1'b0}}, k};
  assign rd_addr_a = sum_a[ADDR_W-1:0];
  assign rd_addr_b = sum_b[ADDR_W-1:0];

  // result fields
  assign sky_wide = {{spc_pkg::OUT_W{1'b0}}, sky};
  assign n_wide   = {{spc_pkg::OUT_W{1'b0}}, n};
  assign res_valid            = (state == W_DONE);
  assign result.skyline_count = sky_wide[spc_pkg::OUT_W-1:0];
  assign result.point_count   = n_wide[spc_pkg::OUT_W-1:0];
  assign result.overflow      = ovf_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= W_IDLE;
      rem    <= '0;
      n      <= '0;
      i      <= '0;
      j      <= '0;
      sky    <= '0;
      base_i <= '0;
      base_j <= '0;
      k      <= '0;
      sd_r   <= '0;
      ed_r   <= '0;
      ovf_r  <= 1'b0;
    end else begin
      unique case (state)
        W_IDLE: begin
          if (start) begin
            rem    <= total;
            n      <= '0;
            i      <= '0;
            sky    <= '0;
            base_i <= '0;
            sd_r   <= job.sd;
            ed_r   <= job.ed;
            ovf_r  <= job.ovf;
            state  <= W_DIV;
          end
        end
        // count whole points, saturating at capacity
        W_DIV: begin
          if (neg || n == PT_W'(MAX_POINTS)) begin
            state <= W_ROW_I;
          end else begin
            rem <= diff[CNT_W-1:0];
            n   <= n + 1'b1;
          end
        end
        W_ROW_I: begin
          if (i == n) begin
            state <= W_DONE;
          end else begin
            j      <= '0;
            base_j <= '0;
            state  <= W_ROW_J;
          end
        end
        W_ROW_J: begin
          if (j == n) begin
            // no row dominates row i
            sky    <= sky + 1'b1;
            i      <= i + 1'b1;
            base_i <= base_i + sd_ext;
            state  <= W_ROW_I;
          end else if (i == j) begin
            j      <= j + 1'b1;
            base_j <= base_j + sd_ext;
          end else begin
            k     <= '0;
            state <= W_READ;
          end
        end
        W_READ: begin
          state <= W_CMP;
        end
        W_CMP: begin
          if (!neg) begin
            // not strictly smaller: try next row j
            j      <= j + 1'b1;
            base_j <= base_j + sd_ext;
            state  <= W_ROW_J;
          end else if (k == ed_r - 1'b1) begin
            // dominated: drop row i
            i      <= i + 1'b1;
            base_i <= base_i + sd_ext;
            state  <= W_ROW_I;
          end else begin
            k     <= k + 1'b1;
            state <= W_READ;
          end
        end
        W_DONE: begin
          if (res_ready) begin
            state <= W_IDLE;
          end
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

  a_row_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == W_ROW_J) |-> (i < n) && (j <= n))
    else $error("row index out of range during walk");

  a_dim_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == W_CMP) |-> (k < ed_r))
    else $error("coordinate index beyond compared dims");

  a_sky_bound: assert property (@(posedge clk) disable iff (rst)
    (sky <= i) && (n <= PT_W'(MAX_POINTS)))
    else $error("skyline count exceeds rows visited");

endmodule

FILE: src/skyline_point_counter.sv
// Top level of the skyline point counter: stream and config ports, load counter,
// mirrored point stores and output register. Uses spc_pkg, spc_ram and spc_walk.
// Loading takes one coordinate a cycle while s_tready is high. The request flagged
// last then holds the shared subtractor for point counting and then the dominance
// walk, with s_tready low until the result is taken by the output register.
// Reset clears load state and output valid, sets stored_dims 16, eval_dims 0.
module skyline_point_counter #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_DIMS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // [15:0] coord
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,   // [10:0] skyline_count,
                                                 // [21:11] point_count,
                                                 // [22] overflow, [23] zero
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [spc_pkg::CFG_W-1:0]   cfg_data
);

  localparam int DEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CW     = spc_pkg::CFG_W;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_BUSY = 2'b10
  } top_state_t;

  top_state_t           state;
  logic [CW-1:0]        stored_dims;
  logic [CW-1:0]        eval_dims;
  logic [CNT_W-1:0]     coord_counter;
  logic                 overflow_flag;

  logic [CW-1:0]        sd_eff;
  logic [CW-1:0]        ed_eff;
  logic [CNT_W-1:0]     cap;
  logic                 acc;
  logic                 store_ok;
  logic                 we;
  logic                 start;
  logic [CNT_W-1:0]     total;
  spc_pkg::spc_job_t    job;
  logic [ADDR_W-1:0]    rd_addr_a;
  logic [ADDR_W-1:0]    rd_addr_b;
  logic [15:0]          rd_data_a;
  logic [15:0]          rd_data_b;
  logic                 res_valid;
  logic                 res_ready;
  spc_pkg::spc_result_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_dims <= CW'(16);
      eval_dims   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spc_pkg::REG_STORED_DIMS: stored_dims <= cfg_data;
        spc_pkg::REG_EVAL_DIMS:   eval_dims   <= cfg_data;
        default:                  stored_dims <= stored_dims;
      endcase
    end
  end

  // clamp stride and compared dims
  always_comb begin
    sd_eff = stored_dims;
    if (stored_dims == '0) begin
      sd_eff = CW'(1);
    end else if (32'(stored_dims) > MAX_DIMS) begin
      sd_eff = CW'(MAX_DIMS);
    end
    ed_eff = eval_dims;
    if (eval_dims == '0 || eval_dims > sd_eff) begin
      ed_eff = sd_eff;
    end
  end

  assign cap      = CNT_W'(MAX_POINTS * 32'(sd_eff));
  assign s_tready = (state == ST_LOAD);
  assign acc      = s_tvalid && s_tready;
  assign store_ok = coord_counter < cap;
  assign we       = acc && store_ok;
  assign start    = acc && s_tlast;
  assign total    = store_ok ? coord_counter + 1'b1 : coord_counter;
  assign job.sd   = sd_eff;
  assign job.ed   = ed_eff;
  assign job.ovf  = overflow_flag || !store_ok;

  // load counter, overflow flag and busy state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      coord_counter <= '0;
      overflow_flag <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (start) begin
            coord_counter <= '0;
            overflow_flag <= 1'b0;
            state         <= ST_BUSY;
          end else if (acc) begin
            if (store_ok) begin
              coord_counter <= coord_counter + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
          end
        end
        ST_BUSY: begin
          if (res_valid && res_ready) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // two mirrored stores give one read port per compared row
  spc_ram #(.WIDTH(spc_pkg::COORD_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (coord_counter[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (rd_addr_a),
    .rdata (rd_data_a)
  );

  spc_ram #(.WIDTH(spc_pkg::COORD_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (coord_counter[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (rd_addr_b),
    .rdata (rd_data_b)
  );

  spc_walk #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS)) u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .job       (job),
    .total     (total),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result)
  );

  // output register: take a result when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, result.overflow, result.point_count, result.skyline_count};
    end
  end

  a_walk_idle_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !res_valid)
    else $error("walk result present while loading");

  a_last_starts_walk: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_BUSY) && (coord_counter == '0) && !overflow_flag)
    else $error("last request did not start the walk");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> m_tvalid && (state == ST_LOAD))
    else $error("result not moved to the output register");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for skyline_point_counter: streams point sets,
// predicts each skyline result in-bench and checks it at the output stream.
// Depends on spc_pkg and the skyline_point_counter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS    = 1024;
  localparam int MAX_DIMS      = 16;
  localparam int STORE_DEPTH   = MAX_POINTS * MAX_DIMS;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 450;
  localparam int RANDOM_SETS   = 48;

  // coordinate styles for random point sets
  typedef enum int {VAL_NARROW, VAL_FULL, VAL_EXTREME} value_mode_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         s_tvalid  = 1'b0;
  logic [15:0]                  s_tdata   = '0;
  logic                         s_tlast   = 1'b0;
  logic                         m_tready  = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic                         cfg_index = spc_pkg::REG_STORED_DIMS;
  logic [spc_pkg::CFG_W-1:0]    cfg_data  = '0;
  wire                          s_tready;
  wire                          m_tvalid;
  wire  [23:0]                  m_tdata;

  // skyline predictor: coordinate store, load state and register copies
  logic signed [15:0]           coord_store [STORE_DEPTH];
  int unsigned                  coord_fill = 0;
  bit                           dropped    = 1'b0;
  logic [spc_pkg::CFG_W-1:0]    stored_reg = 5'd16;
  logic [spc_pkg::CFG_W-1:0]    eval_reg   = 5'd0;
  spc_pkg::spc_result_t         skyline_results [$];

  int                           err_cnt    = 0;
  int unsigned                  idle_pct   = 0;
  int unsigned                  stall_pct  = 0;
  int unsigned                  random_requests = 0;
  int unsigned                  random_sets     = 0;
  spc_pkg::spc_result_t         got_result;
  spc_pkg::spc_result_t         want_result;

  skyline_point_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stall the result side at the current rate
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic bit reg_is_zero(input logic [spc_pkg::CFG_W-1:0] v);
    return (v == '0);
  endfunction

  // effective row stride: 0 reads as 1, large values clamp to MAX_DIMS
  function automatic int unsigned row_stride();
    if (reg_is_zero(stored_reg)) return 1;
    if (stored_reg > MAX_DIMS) return MAX_DIMS;
    return stored_reg;
  endfunction

  // true when row a lies strictly below row b in the first e coordinates
  function automatic bit below_in_all(input int unsigned a, input int unsigned b,
                                      input int unsigned sd, input int unsigned e);
    int unsigned k;
    for (k = 0; k < e; k++) begin
      if (coord_store[a*sd + k] >= coord_store[b*sd + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // store one accepted coordinate; on the last one, count the skyline
  function automatic void take_coord(input logic [15:0] c, input logic last);
    int unsigned          sd, e, n, sky, i, j;
    bit                   beaten;
    spc_pkg::spc_result_t r;
    sd = row_stride();
    if (coord_fill < MAX_POINTS * sd) begin
      coord_store[coord_fill] = c;
      coord_fill++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    e = eval_reg;
    if (e == 0 || e > sd) e = sd;
    n = coord_fill / sd;
    if (n > MAX_POINTS) n = MAX_POINTS;
    sky = 0;
    for (i = 0; i < n; i++) begin
      beaten = 1'b0;
      for (j = 0; j < n && !beaten; j++) begin
        if (i != j && below_in_all(i, j, sd, e)) beaten = 1'b1;
      end
      if (!beaten) sky++;
    end
    r.skyline_count = sky[spc_pkg::OUT_W-1:0];
    r.point_count   = n[spc_pkg::OUT_W-1:0];
    r.overflow      = dropped;
    skyline_results.push_back(r);
    coord_fill = 0;
    dropped    = 1'b0;
  endfunction

  // check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result = m_tdata[22:0];
      if (skyline_results.size() == 0) begin
        $error("result with no request pending: m_tdata=%h", m_tdata);
        err_cnt++;
      end else begin
        want_result = skyline_results.pop_front();
        if (got_result.skyline_count !== want_result.skyline_count) begin
          $error("skyline_count: expected %0d, got %0d",
                 want_result.skyline_count, got_result.skyline_count);
          err_cnt++;
        end
        if (got_result.point_count !== want_result.point_count) begin
          $error("point_count: expected %0d, got %0d",
                 want_result.point_count, got_result.point_count);
          err_cnt++;
        end
        if (got_result.overflow !== want_result.overflow) begin
          $error("overflow: expected %0d, got %0d",
                 want_result.overflow, got_result.overflow);
          err_cnt++;
        end
        if (m_tdata[23] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_tdata[23]);
          err_cnt++;
        end
      end
    end
  end

  // drive one request, idling first at the current rate, and wait for accept
  task automatic send_request(input logic [15:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    take_coord(c, last);
  endtask

  // send a whole set, flag the final coordinate, then release the bus
  task automatic send_set(input logic [15:0] coords [$]);
    int i;
    for (i = 0; i < coords.size(); i++) begin
      send_request(coords[i], i == coords.size() - 1);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
  endtask

  // wait until every predicted result is out and the walk has settled
  task automatic drain();
    while (skyline_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [spc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == spc_pkg::REG_STORED_DIMS) stored_reg = val;
    else eval_reg = val;
  endtask

  task automatic configure(input int unsigned sd, input int unsigned ed);
    drain();
    write_reg(spc_pkg::REG_STORED_DIMS, sd[spc_pkg::CFG_W-1:0]);
    write_reg(spc_pkg::REG_EVAL_DIMS, ed[spc_pkg::CFG_W-1:0]);
  endtask

  function automatic logic [15:0] rand_coord(input value_mode_t mode);
    case (mode)
      VAL_NARROW: return 16'($urandom_range(6)) - 16'd3;
      VAL_FULL:   return 16'($urandom);
      default: begin
        case ($urandom_range(5))
          0:       return 16'h8000;
          1:       return 16'h8001;
          2:       return 16'hFFFF;
          3:       return 16'h0000;
          4:       return 16'h0001;
          default: return 16'h7FFF;
        endcase
      end
    endcase
  endfunction

  // one random set: whole points, sometimes a partial point at the tail
  task automatic random_set();
    logic [15:0] q [$];
    int unsigned sd, n, tail, max_pts;
    value_mode_t mode;
    sd      = row_stride();
    max_pts = (sd <= 2) ? 12 : (sd <= 5) ? 6 : 3;
    n       = $urandom_range(max_pts);
    tail    = ($urandom_range(4) == 0) ? $urandom_range(sd - 1) : 0;
    mode    = value_mode_t'($urandom_range(2));
    repeat (n * sd + tail) q.push_back(rand_coord(mode));
    if (q.size() == 0) q.push_back(rand_coord(mode));
    random_requests += q.size();
    random_sets++;
    send_set(q);
  endtask

  // reset values: stride 16, all dims compared; one point plus a partial one
  task automatic test_reset_defaults();
    logic [15:0] q [$];
    q = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001,
          16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00, 16'h1234, 16'hEDCB, 16'h0F0F,
          16'hF0F0, 16'h3C3C, 16'h0007};
    send_set(q);
  endtask

  // ties, extremes, partial dims, a trailing partial point and a set with no whole point
  task automatic test_dominance_cases();
    logic [15:0] q [$];
    configure(2, 0);
    q = '{16'd3, 16'd3, 16'd3, 16'd3};
    send_set(q);
    q = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF};
    send_set(q);
    configure(2, 1);
    q = '{16'd0, 16'd9, 16'd1, 16'd0};
    send_set(q);
    q = '{16'd5};
    send_set(q);
    q = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd7};
    send_set(q);
  endtask

  // out-of-range register values clamp to their legal range
  task automatic test_config_clamp();
    logic [15:0] q [$];
    configure(0, 31);
    q = '{16'hFFFF, 16'h0000, 16'h8000};
    send_set(q);
    configure(31, 0);
    q = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8,
          16'd9, 16'd10, 16'd11, 16'd12, 16'd13, 16'd14, 16'd15, 16'd16};
    send_set(q);
    configure(3, 31);
    q = '{16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd1};
    send_set(q);
  endtask

  // fill the store past capacity; descending values keep the walk short
  task automatic test_capacity_overflow();
    logic [15:0] q [$];
    int k;
    configure(1, 0);
    for (k = 0; k < MAX_POINTS + 2; k++) q.push_back(16'(1200 - k));
    send_set(q);
    q = '{16'd4, 16'd2};
    send_set(q);
  endtask

  // random sets under each idle/stall mix, two register settings per mix
  task automatic test_random_phases();
    int unsigned idle_tab  [4] = '{0, 49, 0, 18};
    int unsigned stall_tab [4] = '{0, 0, 49, 18};
    int unsigned sd_tab   [11] = '{0, 1, 1, 2, 2, 3, 4, 5, 8, 16, 31};
    int unsigned ph, slice, goal;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (slice = 0; slice < 2; slice++) begin
        configure(sd_tab[$urandom_range(10)], $urandom_range(31));
        goal = ph * 2 + slice + 1;
        while (random_requests < goal * RANDOM_ITEMS / 8 ||
               random_sets < goal * RANDOM_SETS / 8) begin
          random_set();
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_dominance_cases();
    test_config_clamp();
    test_capacity_overflow();
    test_random_phases();
    drain();
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #300_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
src/spc_pkg.sv
src/spc_ram.sv
src/spc_walk.sv
src/skyline_point_counter.sv
dv/tb_top.sv
